FILE: hdl/mte_pkg.sv
`timescale 1ns / 1ps
package mte_pkg;

   localparam int PC_W = 4;

   localparam logic [7:0] CH_FROM_EVENT = 8'hFF;
   localparam logic [7:0] BYTE_META     = 8'hFF;
   localparam logic [7:0] BYTE_EOT      = 8'h2F;
   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] TRACK_CH_RST  = 8'hFF;

   typedef enum logic [1:0] {
      OP_CHANNEL   = 2'd0,
      OP_EX_HEADER = 2'd1,
      OP_EX_DATA   = 2'd2,
      OP_END_TRACK = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [27:0] delta_ticks;
      logic [7:0]  status_byte;
      logic [3:0]  event_channel;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic        is_meta;
      logic [7:0]  meta_type;
      logic [7:0]  ex_length;
      logic [7:0]  ex_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef enum logic [3:0] {
      SEL_VLQ3,
      SEL_VLQ2,
      SEL_VLQ1,
      SEL_VLQ0,
      SEL_STATUS_CH,
      SEL_STATUS,
      SEL_FIRST,
      SEL_SECOND,
      SEL_META_TYPE,
      SEL_EX_LENGTH,
      SEL_EX_BYTE,
      SEL_META,
      SEL_EOT,
      SEL_ZERO
   } sel_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_END,
      BR_OP,
      BR_DATA,
      BR_META
   } br_type;

   typedef struct packed {
      sel_type         sel;
      br_type          br;
      logic [PC_W-1:0] target;
   } uc_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] data_count;
      logic       is_meta;
   } seq_cond_type;

   typedef struct packed {
      logic    active;
      sel_type sel;
      logic    last;
   } step_type;

   localparam logic [PC_W-1:0] PC_VLQ3      = 4'd0;
   localparam logic [PC_W-1:0] PC_VLQ2      = 4'd1;
   localparam logic [PC_W-1:0] PC_VLQ1      = 4'd2;
   localparam logic [PC_W-1:0] PC_VLQ0      = 4'd3;
   localparam logic [PC_W-1:0] PC_CHANNEL   = 4'd4;
   localparam logic [PC_W-1:0] PC_TWO_DATA  = 4'd5;
   localparam logic [PC_W-1:0] PC_ONE_DATA  = 4'd7;
   localparam logic [PC_W-1:0] PC_EX_HEADER = 4'd8;
   localparam logic [PC_W-1:0] PC_EX_LENGTH = 4'd10;
   localparam logic [PC_W-1:0] PC_END_TRACK = 4'd11;
   localparam logic [PC_W-1:0] PC_EX_DATA   = 4'd14;
   localparam logic [PC_W-1:0] PC_LAST      = 4'd14;

   function automatic uc_type mte_ucode(input logic [PC_W-1:0] pc);
      uc_type uc;
      uc.target = PC_VLQ3;
      case (pc)
         4'd0:    begin uc.sel = SEL_VLQ3;      uc.br = BR_NEXT; end
         4'd1:    begin uc.sel = SEL_VLQ2;      uc.br = BR_NEXT; end
         4'd2:    begin uc.sel = SEL_VLQ1;      uc.br = BR_NEXT; end
         4'd3:    begin uc.sel = SEL_VLQ0;      uc.br = BR_OP;   end
         4'd4:    begin
            uc.sel    = SEL_STATUS_CH;
            uc.br     = BR_DATA;
            uc.target = PC_ONE_DATA;
         end
         4'd5:    begin uc.sel = SEL_FIRST;     uc.br = BR_NEXT; end
         4'd6:    begin uc.sel = SEL_SECOND;    uc.br = BR_END;  end
         4'd7:    begin uc.sel = SEL_FIRST;     uc.br = BR_END;  end
         4'd8:    begin
            uc.sel    = SEL_STATUS;
            uc.br     = BR_META;
            uc.target = PC_EX_LENGTH;
         end
         4'd9:    begin uc.sel = SEL_META_TYPE; uc.br = BR_NEXT; end
         4'd10:   begin uc.sel = SEL_EX_LENGTH; uc.br = BR_END;  end
         4'd11:   begin uc.sel = SEL_META;      uc.br = BR_NEXT; end
         4'd12:   begin uc.sel = SEL_EOT;       uc.br = BR_NEXT; end
         4'd13:   begin uc.sel = SEL_ZERO;      uc.br = BR_END;  end
         4'd14:   begin uc.sel = SEL_EX_BYTE;   uc.br = BR_END;  end
         default: begin uc.sel = SEL_ZERO;      uc.br = BR_END;  end
      endcase
      return uc;
   endfunction

   function automatic logic [PC_W-1:0] mte_entry(input req_type r);
      logic [PC_W-1:0] pc;
      if (r.operation == OP_EX_DATA) begin
         pc = PC_EX_DATA;
      end else if (r.delta_ticks[27:21] != 7'd0) begin
         pc = PC_VLQ3;
      end else if (r.delta_ticks[20:14] != 7'd0) begin
         pc = PC_VLQ2;
      end else if (r.delta_ticks[13:7] != 7'd0) begin
         pc = PC_VLQ1;
      end else begin
         pc = PC_VLQ0;
      end
      return pc;
   endfunction

endpackage

FILE: hdl/mte_sequencer.sv
`timescale 1ns / 1ps
module mte_sequencer
   import mte_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            launch,
   input  logic [PC_W-1:0] launch_pc,
   input  seq_cond_type    cond,
   output step_type        step,
   output logic            busy
);

   logic            run_ff;
   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            fin;
   uc_type          uc;

   assign uc = mte_ucode(pc_ff);

   always_comb begin
      pc_in = pc_ff + 1'b1;
      fin   = 1'b0;
      case (uc.br)
         BR_NEXT: pc_in = pc_ff + 1'b1;
         BR_END:  fin = 1'b1;
         BR_OP: begin
            case (cond.operation)
               OP_CHANNEL:   pc_in = PC_CHANNEL;
               OP_EX_HEADER: pc_in = PC_EX_HEADER;
               default:      pc_in = PC_END_TRACK;
            endcase
         end
         BR_DATA: begin
            case (cond.data_count)
               2'd0:    fin   = 1'b1;
               2'd1:    pc_in = uc.target;
               default: pc_in = PC_TWO_DATA;
            endcase
         end
         BR_META: begin
            if (!cond.is_meta) begin
               pc_in = uc.target;
            end
         end
         default: fin = 1'b1;
      endcase
   end

   assign step.active = run_ff;
   assign step.sel    = uc.sel;
   assign step.last   = run_ff & fin;
   assign busy        = run_ff & ~fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff  <= PC_VLQ3;
      end else if (launch) begin
         run_ff <= 1'b1;
         pc_ff  <= launch_pc;
      end else if (run_ff && fin) begin
         run_ff <= 1'b0;
      end else if (run_ff) begin
         pc_ff <= pc_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_launch_runs: assert property (@(posedge clock) disable iff (reset)
      launch |=> run_ff)
      else $error("sequencer not running after launch");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (step.last && !launch) |=> !run_ff)
      else $error("sequencer still running after last step");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (pc_ff <= PC_LAST))
      else $error("step counter outside program");

   a_launch_idle_only: assert property (@(posedge clock) disable iff (reset)
      launch |-> !busy)
      else $error("launch while busy");
`endif

endmodule

FILE: hdl/midi_track_event_encoder.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Transfer
// request   start, busy, req_data (req_type)        start high and busy low
// response  rsp_strobe, rsp_data (rsp_type)         every cycle rsp_strobe is high
// csr       csr_valid, csr_ready, csr_data [7:0]    csr_valid and csr_ready high
//
// An item of n bytes (1 to 7) runs n steps of the microcode, one per cycle;
// busy stays high until the last step, so a new start is taken in the last step.
// Each byte leaves in the cycle after its step, on rsp_strobe for one cycle.
// Reset clears the sequencer and sets track_channel to 255.
// The receiver cannot stall; no result is held back.
module midi_track_event_encoder
   import mte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   req_type      req_ff;
   logic [7:0]   track_channel_ff;
   logic         rsp_strobe_ff;
   rsp_type      rsp_data_ff;
   logic         launch;
   seq_cond_type cond;
   step_type     step;
   logic [7:0]   channel;
   logic [7:0]   byte_in;

   assign launch    = start & ~busy;
   assign csr_ready = 1'b1;

   always_comb begin
      cond.operation = req_ff.operation;
      cond.is_meta   = req_ff.is_meta;
      case (req_ff.status_byte[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: cond.data_count = 2'd2;
         4'hC, 4'hD:                   cond.data_count = 2'd1;
         default:                      cond.data_count = 2'd0;
      endcase
   end

   mte_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .launch_pc (mte_entry(req_data)),
      .cond      (cond),
      .step      (step),
      .busy      (busy)
   );

   assign channel = (track_channel_ff == CH_FROM_EVENT) ?
                    {4'd0, req_ff.event_channel} : track_channel_ff;

   always_comb begin
      case (step.sel)
         SEL_VLQ3:      byte_in = {1'b1, req_ff.delta_ticks[27:21]};
         SEL_VLQ2:      byte_in = {1'b1, req_ff.delta_ticks[20:14]};
         SEL_VLQ1:      byte_in = {1'b1, req_ff.delta_ticks[13:7]};
         SEL_VLQ0:      byte_in = {1'b0, req_ff.delta_ticks[6:0]};
         SEL_STATUS_CH: byte_in = req_ff.status_byte | channel;
         SEL_STATUS:    byte_in = req_ff.status_byte;
         SEL_FIRST:     byte_in = req_ff.first_data;
         SEL_SECOND:    byte_in = req_ff.second_data;
         SEL_META_TYPE: byte_in = req_ff.meta_type;
         SEL_EX_LENGTH: byte_in = req_ff.ex_length;
         SEL_EX_BYTE:   byte_in = req_ff.ex_byte;
         SEL_META:      byte_in = BYTE_META;
         SEL_EOT:       byte_in = BYTE_EOT;
         default:       byte_in = BYTE_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_channel_ff <= TRACK_CH_RST;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            track_channel_ff <= csr_data;
         end
         rsp_strobe_ff <= step.active;
      end
      if (launch) begin
         req_ff <= req_data;
      end
      rsp_data_ff.out_byte  <= byte_in;
      rsp_data_ff.last_byte <= step.last;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: verif/midi_track_event_encoder_tb.sv
`timescale 1ns / 1ps
module midi_track_event_encoder_tb;
   import mte_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 370;
   localparam int MAX_SHOWN = 40;

   class track_byte_board;
      rsp_type     pending_bytes[$];
      logic [7:0]  channel_reg;
      int unsigned mismatches;
      int unsigned bytes_checked;

      function new();
         channel_reg   = TRACK_CH_RST;
         mismatches    = 0;
         bytes_checked = 0;
      endfunction

      function void set_channel(logic [7:0] value);
         channel_reg = value;
      endfunction

      function void add_delta(ref logic [7:0] run[$], input logic [27:0] delta);
         int groups;
         logic [7:0] b;
         groups = 1;
         while (groups < 4 && (delta >> (7 * groups)) != 0) groups++;
         for (int g = groups - 1; g >= 0; g--) begin
            b = {1'b0, 7'((delta >> (7 * g)) & 28'h7F)};
            if (g > 0) b[7] = 1'b1;
            run.push_back(b);
         end
      endfunction

      function void note_item(req_type r);
         logic [7:0] run[$];
         logic [7:0] ch;
         rsp_type    e;
         case (op_type'(r.operation))
            OP_CHANNEL: begin
               ch = (channel_reg == CH_FROM_EVENT) ? {4'h0, r.event_channel} : channel_reg;
               add_delta(run, r.delta_ticks);
               run.push_back(r.status_byte | ch);
               case (r.status_byte[7:4])
                  4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
                     run.push_back(r.first_data);
                     run.push_back(r.second_data);
                  end
                  4'hC, 4'hD: begin
                     run.push_back(r.first_data);
                  end
                  default: ;
               endcase
            end
            OP_EX_HEADER: begin
               add_delta(run, r.delta_ticks);
               run.push_back(r.status_byte);
               if (r.is_meta) run.push_back(r.meta_type);
               run.push_back(r.ex_length);
            end
            OP_EX_DATA: begin
               run.push_back(r.ex_byte);
            end
            default: begin
               add_delta(run, r.delta_ticks);
               run.push_back(BYTE_META);
               run.push_back(BYTE_EOT);
               run.push_back(BYTE_ZERO);
            end
         endcase
         foreach (run[i]) begin
            e.out_byte  = run[i];
            e.last_byte = (i == run.size() - 1);
            pending_bytes.push_back(e);
         end
      endfunction

      task report_mismatch(string what);
         if (mismatches < MAX_SHOWN)
            $display("%0d ns: mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_byte(rsp_type got);
         rsp_type want;
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h with nothing pending", got.out_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                         got.out_byte, want.out_byte));
            if (got.last_byte !== want.last_byte)
               report_mismatch($sformatf("last_byte %0b, wanted %0b on byte %02h",
                                         got.last_byte, want.last_byte, want.out_byte));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   track_byte_board board = new();
   int unsigned     cycles;
   int unsigned     items_sent;
   int unsigned     op_count[4];
   int unsigned     burst_left;
   int unsigned     settings_used;

   midi_track_event_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("midi_track_event_encoder_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_byte(rsp_data);
   end

   function automatic logic [27:0] pick_delta();
      logic [27:0] d;
      case ($urandom_range(0, 5))
         0: d = 28'($urandom_range(0, 127));
         1: d = 28'($urandom_range(0, 16383));
         2: d = 28'($urandom_range(0, 2097151));
         3: d = 28'($urandom);
         4: d = 28'h0FFFFFFF;
         default: d = 28'(1 << $urandom_range(0, 27)) - 28'($urandom_range(0, 1));
      endcase
      return d;
   endfunction

   function automatic req_type pick_fields(op_type op);
      req_type r;
      r.operation     = op;
      r.delta_ticks   = pick_delta();
      r.status_byte   = 8'($urandom);
      r.event_channel = 4'($urandom);
      r.first_data    = 8'($urandom);
      r.second_data   = 8'($urandom);
      r.is_meta       = 1'($urandom);
      r.meta_type     = 8'($urandom);
      r.ex_length     = 8'($urandom);
      r.ex_byte       = 8'($urandom);
      return r;
   endfunction

   task automatic send_item(req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_item(r);
      items_sent++;
      op_count[r.operation]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_channel(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_channel(value);
      settings_used++;
   endtask

   task automatic random_sequence();
      req_type r;
      int      n;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            r = pick_fields(OP_CHANNEL);
            if ($urandom_range(0, 3) != 0) r.status_byte[3:0] = 4'h0;
            if ($urandom_range(0, 3) != 0) r.status_byte[7] = 1'b1;
            send_item(r);
         end
         12, 13, 14, 15: begin
            r = pick_fields(OP_EX_HEADER);
            r.status_byte = r.is_meta ? BYTE_META : 8'hF0;
            if ($urandom_range(0, 1)) r.ex_length = 8'($urandom_range(0, 6));
            send_item(r);
            n = (r.ex_length > 6) ? $urandom_range(0, 6) : r.ex_length;
            repeat (n) send_item(pick_fields(OP_EX_DATA));
         end
         16: begin
            send_item(pick_fields(OP_END_TRACK));
         end
         default: begin
            send_item(pick_fields(op_type'($urandom_range(0, 3))));
         end
      endcase
   endtask

   logic [27:0] delta_edges[8] = '{28'h0, 28'h7F, 28'h80, 28'h3FFF, 28'h4000,
                                   28'h1FFFFF, 28'h200000, 28'h0FFFFFFF};
   logic [7:0]  channel_plan[6] = '{8'h00, 8'h0F, 8'h5A, 8'hFE, 8'h00, CH_FROM_EVENT};

   initial begin
      req_type r;
      int      per_phase;
      cycles        = 0;
      items_sent    = 0;
      burst_left    = 0;
      settings_used = 1;
      foreach (op_count[i]) op_count[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 16; i++) begin
         r = pick_fields(OP_CHANNEL);
         r.status_byte = {4'(i), 4'h0};
         r.delta_ticks = delta_edges[i % 8];
         r.first_data  = (i % 2) ? 8'hFF : 8'h00;
         r.second_data = (i % 2) ? 8'h00 : 8'hFF;
         send_item(r);
      end
      r = pick_fields(OP_CHANNEL);
      r.status_byte   = 8'h9A;
      r.event_channel = 4'h5;
      send_item(r);
      r = pick_fields(OP_EX_HEADER);
      r.status_byte = BYTE_META;
      r.is_meta     = 1'b1;
      r.meta_type   = 8'h01;
      r.ex_length   = 8'h02;
      send_item(r);
      r = pick_fields(OP_EX_DATA);
      r.ex_byte = 8'h00;
      send_item(r);
      r.ex_byte = 8'hFF;
      send_item(r);
      r = pick_fields(OP_EX_HEADER);
      r.status_byte = 8'hF0;
      r.is_meta     = 1'b0;
      r.ex_length   = 8'hFF;
      send_item(r);
      r = pick_fields(OP_END_TRACK);
      r.delta_ticks = 28'h0FFFFFFF;
      send_item(r);
      drain();

      per_phase = (ITEM_TARGET - items_sent) / $size(channel_plan);
      foreach (channel_plan[p]) begin
         write_channel((p == 4) ? 8'($urandom) : channel_plan[p]);
         r = pick_fields(OP_CHANNEL);
         r.status_byte = 8'hE7;
         send_item(r);
         while (items_sent < 23 + per_phase * (p + 1)) random_sequence();
         drain();
      end

      $display("covered %0d items (%0d channel, %0d header, %0d payload, %0d end of track)",
               items_sent, op_count[OP_CHANNEL], op_count[OP_EX_HEADER],
               op_count[OP_EX_DATA], op_count[OP_END_TRACK]);
      $display("checked %0d track bytes under %0d channel settings, %0d mismatches",
               board.bytes_checked, settings_used, board.mismatches);
      if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
         $display("midi_track_event_encoder_tb: done, clean");
      end else begin
         $display("midi_track_event_encoder_tb: done, errors");
      end
      $finish;
   end

endmodule
